// File: hw/rtl/assert_macros.svh
// assertion helpers included by the rtl top module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: hw/rtl/utcep_pkg.sv
// ---------------------------------------------------------------------------
// utcep_pkg
// constants, widths and calendar tables for the utc to epoch converter
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package utcep_pkg;

    // width of the years-since-1900 field, 8 to 31
    localparam int YEAR_BITS = 14;

    localparam int EPOCH_YEAR = 1970;
    localparam int YEAR_BASE  = 1900;

    // full calendar year, wide enough for the field plus the base year
    localparam int YEAR_W = ((YEAR_BITS > 11) ? YEAR_BITS : 11) + 1;
    // year / 4
    localparam int QUAD_W = YEAR_W - 2;

    // quad / 25 by reciprocal multiply, the estimate is at most one low
    localparam int DIV_CONST = 25;
    localparam int DIV_SHIFT = QUAD_W + 5;
    localparam longint unsigned DIV25_MUL = (64'd1 << DIV_SHIFT) / DIV_CONST;
    localparam int MUL_W  = QUAD_W + DIV_SHIFT - 4;
    localparam int CENT_W = QUAD_W - 4;
    localparam int REM_W  = 5;

    localparam int SEC_W  = 39;
    localparam int DAYS_W = ((YEAR_W + 9) > SEC_W) ? SEC_W : (YEAR_W + 9);
    localparam int TOD_W  = 17;
    localparam int PART_W = 9;

    // leap days up to jan 1 of year y: (y-1)/4 - (y-1)/100 + (y-1)/400 - bias
    localparam int LEAP_DAY_BIAS = 477;

    localparam int DAYS_PER_YEAR  = 365;
    localparam int SECS_PER_DAY   = 86400;
    localparam int SECS_PER_HOUR  = 3600;
    localparam int SECS_PER_MIN   = 60;
    localparam int MONTH_FEB      = 1;
    localparam int LAST_MONTH     = 11;
    localparam int FEB_LEAP_LEN   = 29;
    localparam int MAX_HOUR       = 23;
    localparam int MAX_MINUTE     = 59;
    localparam int MAX_SECOND     = 60;

    // length of a month, zero for codes above december
    function automatic logic [4:0] month_len(input logic [3:0] mon);
        logic [4:0] len;
        case (mon)
            4'd0:    len = 5'd31;
            4'd1:    len = 5'd28;
            4'd2:    len = 5'd31;
            4'd3:    len = 5'd30;
            4'd4:    len = 5'd31;
            4'd5:    len = 5'd30;
            4'd6:    len = 5'd31;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd30;
            4'd9:    len = 5'd31;
            4'd10:   len = 5'd30;
            4'd11:   len = 5'd31;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

    // days in the year before the first of a month
    function automatic logic [8:0] days_before_month(input logic [3:0] mon);
        logic [8:0] d;
        case (mon)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// File: hw/rtl/utc_date_to_epoch_seconds_top.sv
// ---------------------------------------------------------------------------
// utc_date_to_epoch_seconds_top
// broken-down utc date and time to seconds since 1970-01-01, six-stage pipe
// ---------------------------------------------------------------------------
// channel   dir  handshake           payload
// s_        in   s_valid / s_ready   year, month, day, hour, minute, second
// m_        out  m_valid / m_ready   epoch seconds, valid flag
//
// one transaction per cycle sustained while m_ready stays high; the accepting edge
// loads stage 1 and the transaction then moves through stages 2 to 6, m_valid
// being the stage 6 valid register (one register stage per step of the datapath)
// the longest paths are the divide-by-25 reciprocal multiply and the
// days times 86400 multiply, each with its own stage
// aresetn is synchronous, active low, and clears only the stage valid bits
// a stall at m_ready propagates back stage by stage; empty stages still fill
`timescale 1ns / 1ps

module utc_date_to_epoch_seconds_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [utcep_pkg::YEAR_BITS-1:0] s_years_since_1900,
    input  logic [3:0]                      s_month_index,
    input  logic [4:0]                      s_day_of_month,
    input  logic [4:0]                      s_hour_of_day,
    input  logic [5:0]                      s_minute_of_hour,
    input  logic [5:0]                      s_second_of_minute,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [utcep_pkg::SEC_W-1:0]     m_epoch_seconds,
    output logic                            m_valid_res
);
    import utcep_pkg::*;

    `include "assert_macros.svh"

    // per-stage load enables, a stage loads when empty or when it drains
    logic en1, en2, en3, en4, en5, en6;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;

    assign en6 = !v6_reg || m_ready;
    assign en5 = !v5_reg || en6;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_ready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
            if (en6) v6_reg <= v5_reg;
        end
    end

    // ---------------------------------------------------------------------
    // stage 1: full year, range checks, table lookups, reciprocal multiply
    // ---------------------------------------------------------------------
    logic [YEAR_W-1:0] year1_reg, year1_next;
    logic [QUAD_W-1:0] quad1_reg, quad1_next;
    logic [MUL_W-1:0]  prod1_reg, prod1_next;
    logic [3:0]        mon1_reg;
    logic [4:0]        mday1_reg, hour1_reg;
    logic [5:0]        min1_reg, sec1_reg;
    logic              ok1_reg, ok1_next;
    logic [4:0]        mlen1_reg, mlen1_next;
    logic [8:0]        dbm1_reg, dbm1_next;

    always_comb begin
        year1_next = YEAR_W'(s_years_since_1900) + YEAR_W'(YEAR_BASE);
        quad1_next = year1_next[YEAR_W-1:2];
        prod1_next = MUL_W'(quad1_next) * MUL_W'(DIV25_MUL);
        // everything but the upper bound on the day
        ok1_next   = (year1_next >= YEAR_W'(EPOCH_YEAR))
                  && (s_month_index <= 4'(LAST_MONTH))
                  && (s_day_of_month != 5'd0)
                  && (s_hour_of_day <= 5'(MAX_HOUR))
                  && (s_minute_of_hour <= 6'(MAX_MINUTE))
                  && (s_second_of_minute <= 6'(MAX_SECOND));
        mlen1_next = month_len(s_month_index);
        dbm1_next  = days_before_month(s_month_index);
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            year1_reg <= year1_next;
            quad1_reg <= quad1_next;
            prod1_reg <= prod1_next;
            mon1_reg  <= s_month_index;
            mday1_reg <= s_day_of_month;
            hour1_reg <= s_hour_of_day;
            min1_reg  <= s_minute_of_hour;
            sec1_reg  <= s_second_of_minute;
            ok1_reg   <= ok1_next;
            mlen1_reg <= mlen1_next;
            dbm1_reg  <= dbm1_next;
        end
    end

    // ---------------------------------------------------------------------
    // stage 2: quotient correction, time of day, whole years in days
    // ---------------------------------------------------------------------
    logic [CENT_W-1:0] qest2;
    logic [QUAD_W-1:0] rraw2;
    logic [CENT_W-1:0] q2_reg, q2_next;
    logic [REM_W-1:0]  r2_reg, r2_next;
    logic [QUAD_W-1:0] quad2_reg;
    logic              y4_2_reg, y4_2_next;
    logic              y16_2_reg, y16_2_next;
    logic [3:0]        mon2_reg;
    logic [4:0]        mday2_reg, mlen2_reg;
    logic [8:0]        dbm2_reg;
    logic              ok2_reg;
    logic [TOD_W-1:0]  tod2_reg, tod2_next;
    logic [DAYS_W-1:0] yoff2_reg, yoff2_next;

    always_comb begin
        qest2 = CENT_W'(prod1_reg >> DIV_SHIFT);
        rraw2 = quad1_reg - QUAD_W'(QUAD_W'(qest2) * QUAD_W'(DIV_CONST));
        if (rraw2 >= QUAD_W'(DIV_CONST)) begin
            q2_next = qest2 + CENT_W'(1);
            r2_next = REM_W'(rraw2 - QUAD_W'(DIV_CONST));
        end else begin
            q2_next = qest2;
            r2_next = REM_W'(rraw2);
        end
        y4_2_next  = (year1_reg[1:0] == 2'd0);
        y16_2_next = (year1_reg[3:0] == 4'd0);
        tod2_next  = TOD_W'(hour1_reg) * TOD_W'(SECS_PER_HOUR)
                   + TOD_W'(min1_reg) * TOD_W'(SECS_PER_MIN)
                   + TOD_W'(sec1_reg);
        yoff2_next = DAYS_W'(DAYS_W'(year1_reg) - DAYS_W'(EPOCH_YEAR))
                   * DAYS_W'(DAYS_PER_YEAR);
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            q2_reg    <= q2_next;
            r2_reg    <= r2_next;
            quad2_reg <= quad1_reg;
            y4_2_reg  <= y4_2_next;
            y16_2_reg <= y16_2_next;
            mon2_reg  <= mon1_reg;
            mday2_reg <= mday1_reg;
            mlen2_reg <= mlen1_reg;
            dbm2_reg  <= dbm1_reg;
            ok2_reg   <= ok1_reg;
            tod2_reg  <= tod2_next;
            yoff2_reg <= yoff2_next;
        end
    end

    // ---------------------------------------------------------------------
    // stage 3: leap status, day bound, leap days since epoch, day in year
    // ---------------------------------------------------------------------
    logic              rz3;
    logic              leap3_reg, leap3_next;
    logic              ok3_reg, ok3_next;
    logic [4:0]        dpm3;
    logic [QUAD_W-1:0] bquad3;
    logic [CENT_W-1:0] bcent3;
    logic [QUAD_W-1:0] leapd3_reg, leapd3_next;
    logic [PART_W-1:0] part3_reg, part3_next;
    logic [DAYS_W-1:0] yoff3_reg;
    logic [TOD_W-1:0]  tod3_reg;

    always_comb begin
        rz3        = (r2_reg == REM_W'(0));
        // divisible by 100 means divisible by 4 with quad divisible by 25
        leap3_next = y4_2_reg && (!rz3 || y16_2_reg);
        dpm3       = (leap3_next && (mon2_reg == 4'(MONTH_FEB))) ? 5'(FEB_LEAP_LEN)
                                                                 : mlen2_reg;
        ok3_next   = ok2_reg && (mday2_reg <= dpm3);
        // (year-1)/4 and (year-1)/100 from year/4 and its quotient by 25
        bquad3     = quad2_reg - QUAD_W'(y4_2_reg);
        bcent3     = q2_reg - CENT_W'(y4_2_reg && rz3);
        leapd3_next = bquad3 - QUAD_W'(bcent3) + QUAD_W'(bcent3 >> 2)
                    - QUAD_W'(LEAP_DAY_BIAS);
        part3_next = PART_W'(dbm2_reg)
                   + PART_W'(leap3_next && (mon2_reg > 4'(MONTH_FEB)))
                   + PART_W'(mday2_reg) - PART_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            leap3_reg  <= leap3_next;
            ok3_reg    <= ok3_next;
            leapd3_reg <= leapd3_next;
            part3_reg  <= part3_next;
            yoff3_reg  <= yoff2_reg;
            tod3_reg   <= tod2_reg;
        end
    end

    // ---------------------------------------------------------------------
    // stage 4: total day count
    // ---------------------------------------------------------------------
    logic [DAYS_W-1:0] days4_reg, days4_next;
    logic              ok4_reg;
    logic [TOD_W-1:0]  tod4_reg;

    assign days4_next = yoff3_reg + DAYS_W'(leapd3_reg) + DAYS_W'(part3_reg);

    always_ff @(posedge aclk) begin
        if (en4) begin
            days4_reg <= days4_next;
            ok4_reg   <= ok3_reg;
            tod4_reg  <= tod3_reg;
        end
    end

    // ---------------------------------------------------------------------
    // stage 5: days to seconds, wraps to the output width
    // ---------------------------------------------------------------------
    logic [SEC_W-1:0] dsec5_reg, dsec5_next;
    logic             ok5_reg;
    logic [TOD_W-1:0] tod5_reg;

    assign dsec5_next = SEC_W'(days4_reg) * SEC_W'(SECS_PER_DAY);

    always_ff @(posedge aclk) begin
        if (en5) begin
            dsec5_reg <= dsec5_next;
            ok5_reg   <= ok4_reg;
            tod5_reg  <= tod4_reg;
        end
    end

    // ---------------------------------------------------------------------
    // stage 6: output register, rejected dates read as zero
    // ---------------------------------------------------------------------
    logic [SEC_W-1:0] secs6_reg, secs6_next;
    logic             ok6_reg;

    assign secs6_next = ok5_reg ? (dsec5_reg + SEC_W'(tod5_reg)) : SEC_W'(0);

    always_ff @(posedge aclk) begin
        if (en6) begin
            secs6_reg <= secs6_next;
            ok6_reg   <= ok5_reg;
        end
    end

    assign m_valid         = v6_reg;
    assign m_epoch_seconds = secs6_reg;
    assign m_valid_res     = ok6_reg;

    // ---------------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------------
    // back-pressure reaches the input only with a full pipe
    `ASSERT_SAME(a_ready_full, aclk, aresetn, !s_ready,
                 v1_reg && v2_reg && v3_reg && v4_reg && v5_reg && v6_reg && !m_ready)
    // corrected remainder of the divide by 25 is in range
    `ASSERT_SAME(a_rem_range, aclk, aresetn, v2_reg, r2_reg < REM_W'(DIV_CONST))
    // a rejected transaction carries zero seconds
    `ASSERT_SAME(a_reject_zero, aclk, aresetn, m_valid && !m_valid_res,
                 m_epoch_seconds == SEC_W'(0))
    // a leap year is always a multiple of four
    `ASSERT_NEXT(a_leap_mult4, aclk, aresetn, en3 && v2_reg && !y4_2_reg, !leap3_reg)

endmodule
